// ----- hdl/esd_pkg.sv -----
// Types and constants shared by the event stream decoder modules.
`default_nettype none

package esd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_VARINT  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  localparam logic [3:0] FIRE_TYPE_RESET   = 4'd3;
  localparam logic [2:0] VARINT_MAX_BYTES  = 3'd5;
  localparam logic [1:0] PAYLOAD_LAST_BYTE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } esd_in_t;

  typedef struct packed {
    logic [3:0]  event_type;
    logic [31:0] event_frame;
    logic [31:0] payload_word;
    logic        has_payload;
    logic [1:0]  status;
  } esd_out_t;

  typedef struct packed {
    logic     emit;
    esd_out_t res;
  } esd_result_t;

endpackage

`default_nettype wire

// ----- hdl/esd_parser.sv -----
// Byte parser: header, LEB128 delta and payload state with the result of each beat.
`default_nettype none

module esd_parser
  import esd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire esd_in_t     beat,
  input  wire logic [3:0]  fire_type_code,
  output esd_result_t      result
);

  phase_t      phase, phase_next;
  logic [3:0]  held_type, held_type_next;
  logic [31:0] delta_acc, delta_acc_next;
  logic [2:0]  vcount, vcount_next;
  logic [31:0] pay_acc, pay_acc_next;
  logic [1:0]  pcount, pcount_next;
  logic [31:0] base_frame, base_frame_next;

  logic        last;
  logic        cont;
  logic        is_fire;
  logic [2:0]  vcount_inc;
  logic [31:0] delta_or;
  logic [31:0] pay_or;
  logic [31:0] frame;
  logic [31:0] low7;
  logic [31:0] byte32;

  assign last       = beat.end_of_buffer;
  assign cont       = beat.data_byte[7];
  assign is_fire    = (held_type == fire_type_code);
  assign vcount_inc = vcount + 3'd1;
  assign low7       = {25'd0, beat.data_byte[6:0]};
  assign byte32     = {24'd0, beat.data_byte};
  assign frame      = base_frame + delta_or;

  always_comb begin
    case (vcount)
      3'd0:    delta_or = delta_acc | low7;
      3'd1:    delta_or = delta_acc | (low7 << 7);
      3'd2:    delta_or = delta_acc | (low7 << 14);
      3'd3:    delta_or = delta_acc | (low7 << 21);
      3'd4:    delta_or = delta_acc | (low7 << 28);
      default: delta_or = delta_acc;
    endcase
  end

  always_comb begin
    case (pcount)
      2'd0:    pay_or = pay_acc | byte32;
      2'd1:    pay_or = pay_acc | (byte32 << 8);
      2'd2:    pay_or = pay_acc | (byte32 << 16);
      default: pay_or = pay_acc | (byte32 << 24);
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_HEADER: phase_next = PH_VARINT;
        PH_VARINT: begin
          if (!cont) begin
            phase_next = is_fire ? PH_PAYLOAD : PH_HEADER;
          end else if (vcount_inc >= VARINT_MAX_BYTES) begin
            phase_next = PH_DISCARD;
          end
        end
        PH_PAYLOAD: begin
          if (pcount == PAYLOAD_LAST_BYTE) begin
            phase_next = PH_HEADER;
          end
        end
        PH_DISCARD: phase_next = PH_DISCARD;
        default:    phase_next = PH_HEADER;
      endcase
      if (last) begin
        phase_next = PH_HEADER;
      end
    end
  end

  always_comb begin
    held_type_next  = held_type;
    delta_acc_next  = delta_acc;
    vcount_next     = vcount;
    pay_acc_next    = pay_acc;
    pcount_next     = pcount;
    base_frame_next = base_frame;
    result          = '0;
    result.res.event_type = held_type;
    if (take) begin
      unique case (phase)
        PH_HEADER: begin
          held_type_next = beat.data_byte[7:4];
          delta_acc_next = '0;
          vcount_next    = '0;
          pay_acc_next   = '0;
          pcount_next    = '0;
          result.res.event_type = beat.data_byte[7:4];
          if (last) begin
            result.emit       = 1'b1;
            result.res.status = ST_TRUNCATED;
          end
        end
        PH_VARINT: begin
          delta_acc_next = delta_or;
          vcount_next    = vcount_inc;
          if (!cont) begin
            if (is_fire) begin
              if (last) begin
                result.emit       = 1'b1;
                result.res.status = ST_TRUNCATED;
              end else begin
                delta_acc_next = frame;
              end
            end else begin
              base_frame_next        = frame;
              result.emit            = 1'b1;
              result.res.event_frame = frame;
              result.res.status      = ST_OK;
            end
          end else if (vcount_inc >= VARINT_MAX_BYTES) begin
            result.emit       = 1'b1;
            result.res.status = ST_TOO_LONG;
          end else if (last) begin
            result.emit       = 1'b1;
            result.res.status = ST_TRUNCATED;
          end
        end
        PH_PAYLOAD: begin
          pay_acc_next = pay_or;
          if (pcount == PAYLOAD_LAST_BYTE) begin
            base_frame_next         = delta_acc;
            pcount_next             = '0;
            result.emit             = 1'b1;
            result.res.event_frame  = delta_acc;
            result.res.payload_word = pay_or;
            result.res.has_payload  = 1'b1;
            result.res.status       = ST_OK;
          end else begin
            pcount_next = pcount + 2'd1;
            if (last) begin
              result.emit       = 1'b1;
              result.res.status = ST_TRUNCATED;
            end
          end
        end
        PH_DISCARD: begin
          result.emit = 1'b0;
        end
        default: begin
          result.emit = 1'b0;
        end
      endcase
      if (last) begin
        base_frame_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      held_type  <= '0;
      delta_acc  <= '0;
      vcount     <= '0;
      pay_acc    <= '0;
      pcount     <= '0;
      base_frame <= '0;
    end else begin
      phase      <= phase_next;
      held_type  <= held_type_next;
      delta_acc  <= delta_acc_next;
      vcount     <= vcount_next;
      pay_acc    <= pay_acc_next;
      pcount     <= pcount_next;
      base_frame <= base_frame_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/event_stream_decoder_unit.sv -----
// Top level of the event stream decoder with its configuration register and output stage.
`default_nettype none

// The decoder takes one byte beat per clock cycle while item_ready is high, and parses
// packed events: a header byte whose upper nibble is the type, a LEB128 frame delta of up
// to five bytes, and for the configured fire type a four-byte little-endian payload word.
// Each finished event or detected error gives one result beat, registered into the output
// register or, while the output is stalled, into the skid register; the parse itself is a
// single pass of logic per byte. A two-entry output stage holds results, so item_ready
// comes from a register and input keeps flowing at one byte per cycle while the result
// side accepts a beat every cycle. There is no clearing pass after reset.

module event_stream_decoder_unit
  import esd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire esd_in_t    item,
  output logic            result_valid,
  input  wire logic       result_ready,
  output esd_out_t        result,
  input  wire logic       cfg_write_en,
  input  wire logic [3:0] cfg_write_data
);

  logic [3:0]  fire_code;
  logic        take;
  esd_result_t parsed;
  esd_out_t    skid;
  logic        skid_valid;

  assign item_ready = !skid_valid;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_code <= FIRE_TYPE_RESET;
    end else if (cfg_write_en) begin
      fire_code <= cfg_write_data;
    end
  end

  esd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .beat           (item),
    .fire_type_code (fire_code),
    .result         (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= parsed.emit;
      end
    end else if (parsed.emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result <= skid;
      end else if (parsed.emit) begin
        result <= parsed.res;
      end
    end else if (parsed.emit) begin
      skid <= parsed.res;
    end
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the event stream decoder: directed and random beats against a local decoder.
`timescale 1ns / 100ps

module testbench;
  import esd_pkg::*;

  typedef logic [7:0] byte_list_t[$];

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  esd_in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  esd_out_t result;
  logic cfg_write_en = 1'b0;
  logic [3:0] cfg_write_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int buffers_sent = 0;
  int events_ok = 0;
  int events_truncated = 0;
  int events_too_long = 0;
  int stall_cycles = 0;

  phase_t      dec_phase = PH_HEADER;
  logic [3:0]  dec_type = '0;
  logic [31:0] dec_delta = '0;
  logic [2:0]  dec_vcount = '0;
  logic [31:0] dec_payload = '0;
  logic [1:0]  dec_pcount = '0;
  logic [31:0] dec_base_frame = '0;
  logic [3:0]  fire_code = FIRE_TYPE_RESET;
  esd_out_t    expected_events[$];
  byte_list_t  build_q;

  event_stream_decoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decodes one accepted beat and queues the event or error it completes.
  function automatic void decode_beat(input esd_in_t beat);
    logic [7:0] b;
    logic [31:0] frame;
    int shift;
    bit produced;
    esd_out_t ev;
    b = beat.data_byte;
    produced = 1'b0;
    ev = '0;
    case (dec_phase)
      PH_HEADER: begin
        dec_type = b[7:4];
        dec_delta = '0;
        dec_vcount = '0;
        dec_payload = '0;
        dec_pcount = '0;
        if (beat.end_of_buffer) begin
          produced = 1'b1;
          ev.status = ST_TRUNCATED;
        end else begin
          dec_phase = PH_VARINT;
        end
      end
      PH_VARINT: begin
        shift = 7 * int'(dec_vcount);
        if (shift < 32) dec_delta = dec_delta | ({25'd0, b[6:0]} << shift);
        dec_vcount = dec_vcount + 3'd1;
        if (!b[7]) begin
          frame = dec_base_frame + dec_delta;
          if (dec_type == fire_code) begin
            if (beat.end_of_buffer) begin
              produced = 1'b1;
              ev.status = ST_TRUNCATED;
            end else begin
              dec_delta = frame;
              dec_phase = PH_PAYLOAD;
            end
          end else begin
            dec_base_frame = frame;
            produced = 1'b1;
            ev.event_frame = frame;
            ev.status = ST_OK;
            dec_phase = PH_HEADER;
          end
        end else if (dec_vcount >= VARINT_MAX_BYTES) begin
          produced = 1'b1;
          ev.status = ST_TOO_LONG;
          dec_phase = PH_DISCARD;
        end else if (beat.end_of_buffer) begin
          produced = 1'b1;
          ev.status = ST_TRUNCATED;
        end
      end
      PH_PAYLOAD: begin
        dec_payload = dec_payload | ({24'd0, b} << (8 * int'(dec_pcount)));
        if (dec_pcount >= PAYLOAD_LAST_BYTE) begin
          dec_base_frame = dec_delta;
          produced = 1'b1;
          ev.event_frame = dec_delta;
          ev.payload_word = dec_payload;
          ev.has_payload = 1'b1;
          ev.status = ST_OK;
          dec_pcount = '0;
          dec_phase = PH_HEADER;
        end else begin
          dec_pcount = dec_pcount + 2'd1;
          if (beat.end_of_buffer) begin
            produced = 1'b1;
            ev.status = ST_TRUNCATED;
          end
        end
      end
      default: begin
      end
    endcase
    if (beat.end_of_buffer) begin
      dec_phase = PH_HEADER;
      dec_base_frame = '0;
    end
    if (produced) begin
      ev.event_type = dec_type;
      expected_events.push_back(ev);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input logic [7:0] data, input logic last);
    esd_in_t beat;
    beat.data_byte = data;
    beat.end_of_buffer = last;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= beat;
    do @(posedge clk); while (!item_ready);
    decode_beat(beat);
    beats_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < build_q.size(); i++) send_beat(build_q[i], i == build_q.size() - 1);
    buffers_sent++;
  endtask

  // The sender holds off until the decoder has delivered every pending result.
  task automatic wait_for_drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  task automatic write_fire_code(input logic [3:0] code);
    wait_for_drain();
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= code;
    @(posedge clk);
    fire_code = code;
    cfg_write_en <= 1'b0;
  endtask

  // Appends one event with random content; returns 1 if its delta runs past five bytes.
  function automatic bit append_random_event();
    logic [3:0] kind;
    logic [3:0] low;
    logic [7:0] b;
    int nbytes;
    bit too_long;
    kind = 4'($urandom_range(15));
    if ($urandom_range(1) == 1) kind = fire_code;
    low = 4'($urandom_range(15));
    build_q.push_back({kind, low});
    too_long = ($urandom_range(11) == 0);
    nbytes = too_long ? 5 : $urandom_range(1, 5);
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(127));
      if (too_long || i < nbytes - 1) b[7] = 1'b1;
      build_q.push_back(b);
    end
    if (!too_long && kind == fire_code) begin
      repeat (4) begin
        b = 8'($urandom_range(255));
        build_q.push_back(b);
      end
    end
    return too_long;
  endfunction

  task automatic stream_random_buffers(input int beat_goal);
    int start;
    int pick;
    int count;
    int cut;
    bit broken;
    logic [7:0] b;
    start = beats_sent;
    while (beats_sent - start < beat_goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        count = $urandom_range(1, 12);
        for (int i = 0; i < count; i++) begin
          b = 8'($urandom_range(255));
          send_beat(b, i == count - 1 || $urandom_range(7) == 0);
        end
      end else begin
        build_q.delete();
        broken = 1'b0;
        count = $urandom_range(1, 6);
        for (int e = 0; e < count && !broken; e++) broken = append_random_event();
        if (broken) begin
          repeat ($urandom_range(3)) begin
            b = 8'($urandom_range(255));
            build_q.push_back(b);
          end
        end
        if (pick < 25) begin
          cut = $urandom_range(1, build_q.size());
          while (build_q.size() > cut) void'(build_q.pop_back());
        end
        send_buffer();
      end
      if ($urandom_range(29) == 0) wait_for_drain();
    end
  endtask

  task automatic test_directed_events();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Zero delta, widest delta with dropped upper bits, a wrapping frame, and a
    // payload event that completes on the buffer's last beat.
    build_q = '{8'h05, 8'h00, 8'hF5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                8'h30, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78};
    send_buffer();
    // A header that is the last beat of its buffer.
    build_q = '{8'hFF};
    send_buffer();
    // A delta with too many bytes, then a discarded beat.
    build_q = '{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h11};
    send_buffer();
    // A payload event whose delta ends on the last beat.
    build_q = '{8'h3A, 8'h05};
    send_buffer();
    // A buffer that ends inside the payload.
    build_q = '{8'h30, 8'h01, 8'hAA};
    send_buffer();
    wait_for_drain();
  endtask

  task automatic test_slow_receiver();
    write_fire_code(4'd0);
    send_idle_pct = 16;
    recv_idle_pct = 67;
    stream_random_buffers(400);
  endtask

  task automatic test_slow_sender();
    write_fire_code(4'd15);
    send_idle_pct = 67;
    recv_idle_pct = 16;
    stream_random_buffers(400);
  endtask

  task automatic test_full_rate();
    logic [3:0] code;
    code = 4'($urandom_range(1, 14));
    write_fire_code(code);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stream_random_buffers(400);
  endtask

  always @(posedge clk) begin : result_check
    esd_out_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (result_valid && result_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result beat with none expected", result.event_frame, 32'd0);
        end else begin
          want = expected_events.pop_front();
          if (result.event_type !== want.event_type)
            report_mismatch("event_type", 32'(result.event_type), 32'(want.event_type));
          if (result.event_frame !== want.event_frame)
            report_mismatch("event_frame", result.event_frame, want.event_frame);
          if (result.payload_word !== want.payload_word)
            report_mismatch("payload_word", result.payload_word, want.payload_word);
          if (result.has_payload !== want.has_payload)
            report_mismatch("has_payload", 32'(result.has_payload), 32'(want.has_payload));
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          case (want.status)
            ST_OK: events_ok++;
            ST_TRUNCATED: events_truncated++;
            default: events_too_long++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_events();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    wait_for_drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d byte beats in %0d buffers under four fire type settings.",
             beats_sent, buffers_sent);
    $display("Checked %0d events, %0d truncated buffers and %0d overlong deltas.",
             events_ok, events_truncated, events_too_long);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- event_stream_decoder_unit.f -----
hdl/esd_pkg.sv
hdl/esd_parser.sv
hdl/event_stream_decoder_unit.sv
test/testbench.sv
